>>> hw/rtl/ccrs_pkg.sv
// shared types and constants for the color class run segmenter
// no dependencies
`timescale 1ns / 1ps

package ccrs_pkg;

  localparam int TABLE_AW    = 18;
  localparam int COL_W       = 10;
  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CREDIT_W    = $clog2(QUEUE_DEPTH + 1);

  localparam logic CFG_LIMIT = 1'b0;
  localparam logic CFG_MASK  = 1'b1;

  localparam logic KIND_TABLE = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  typedef struct packed {
    logic [7:0] cls;
    logic       frame_start;
  } class_word_t;

  typedef struct packed {
    logic [7:0]       pixel_class;
    logic             seg_valid;
    logic [COL_W-1:0] seg_row;
    logic [COL_W-1:0] seg_first;
    logic [COL_W-1:0] seg_last_col;
    logic [7:0]       seg_class;
    logic             last;
  } result_t;

  typedef struct packed {
    logic [7:0] usable_class_limit;
    logic [7:0] class_mask;
  } cfg_t;

endpackage

>>> hw/rtl/ccrs_front.sv
// front end: input handshake, quantize, table index pipeline and color table
// depends on ccrs_pkg
`timescale 1ns / 1ps

module ccrs_front #(
  parameter int QUANT_DIVISOR = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         kind,
  input  logic [7:0]                   luma,
  input  logic [7:0]                   chroma_u,
  input  logic [7:0]                   chroma_v,
  input  logic                         frame_start,
  input  logic [ccrs_pkg::TABLE_AW-1:0] table_addr,
  input  logic [7:0]                   table_data,
  input  logic                         pop,
  output logic                         push,
  output ccrs_pkg::class_word_t        push_word
);

  localparam int RECIP_SHIFT = 16;
  localparam logic [16:0] RECIP = 17'((1 << RECIP_SHIFT) / QUANT_DIVISOR + 1);
  localparam logic [8:0] LEVELS = 9'(255 / QUANT_DIVISOR + 1);
  localparam int AW = ccrs_pkg::TABLE_AW;

  function automatic logic [7:0] quant(input logic [7:0] x);
    logic [24:0] prod;
    prod = {17'd0, x} * {8'd0, RECIP};
    return prod[RECIP_SHIFT +: 8];
  endfunction

  logic [ccrs_pkg::CREDIT_W-1:0] used;
  logic                          accept;
  logic                          take_pixel;

  logic          v1, k1, fs1;
  logic [7:0]    qy1, qu1, qv1, data1;
  logic [AW-1:0] addr1;
  logic          v2, k2, fs2;
  logic [7:0]    qv2, data2;
  logic [AW-1:0] t2, addr2;
  logic          v3, k3, fs3;
  logic [7:0]    data3;
  logic [AW-1:0] addr3;
  logic          v4, fs4;
  logic [7:0]    rdata;
  logic [7:0]    mem [1 << AW];

  logic [16:0] t_prod;
  logic [26:0] idx_prod;

  assign in_ready   = used < ccrs_pkg::CREDIT_W'(ccrs_pkg::QUEUE_DEPTH);
  assign accept     = in_valid && in_ready;
  assign take_pixel = accept && (kind == ccrs_pkg::KIND_PIXEL);

  assign t_prod   = 17'({9'd0, qy1} * {8'd0, LEVELS});
  assign idx_prod = 27'({9'd0, t2} * {18'd0, LEVELS});

  // credits cover pixels in flight plus queue entries
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      used <= used + ccrs_pkg::CREDIT_W'(take_pixel) - ccrs_pkg::CREDIT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3 && (k3 == ccrs_pkg::KIND_PIXEL);
    end
  end

  always_ff @(posedge clk) begin
    k1    <= kind;
    fs1   <= frame_start;
    qy1   <= quant(luma);
    qu1   <= quant(chroma_u);
    qv1   <= quant(chroma_v);
    addr1 <= table_addr;
    data1 <= table_data;

    k2    <= k1;
    fs2   <= fs1;
    t2    <= AW'(t_prod) + AW'(qu1);
    qv2   <= qv1;
    addr2 <= addr1;
    data2 <= data1;

    k3    <= k2;
    fs3   <= fs2;
    addr3 <= (k2 == ccrs_pkg::KIND_PIXEL) ? (idx_prod[AW-1:0] + AW'(qv2)) : addr2;
    data3 <= data2;

    fs4   <= fs3;
  end

  always_ff @(posedge clk) begin
    if (v3 && (k3 == ccrs_pkg::KIND_TABLE)) begin
      mem[addr3] <= data3;
    end
    if (v3 && (k3 == ccrs_pkg::KIND_PIXEL)) begin
      rdata <= mem[addr3];
    end
  end

  assign push                  = v4;
  assign push_word.cls         = rdata;
  assign push_word.frame_start = fs4;

endmodule

>>> hw/rtl/ccrs_queue.sv
// short fifo of classified pixel words between front and back
// depends on ccrs_pkg
`timescale 1ns / 1ps

module ccrs_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  ccrs_pkg::class_word_t push_word,
  input  logic                  pop,
  output logic                  q_valid,
  output ccrs_pkg::class_word_t q_word
);

  localparam int PW = ccrs_pkg::QPTR_W;

  ccrs_pkg::class_word_t entries [ccrs_pkg::QUEUE_DEPTH];
  logic [PW-1:0]                 wr_ptr, rd_ptr;
  logic [ccrs_pkg::CREDIT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(ccrs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(ccrs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + ccrs_pkg::CREDIT_W'(push) - ccrs_pkg::CREDIT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_word;
    end
  end

  assign q_valid = count != '0;
  assign q_word  = entries[rd_ptr];

endmodule

>>> hw/rtl/ccrs_back.sv
// back end: run tracking along rows, segment filter and output registers
// depends on ccrs_pkg
`timescale 1ns / 1ps

module ccrs_back #(
  parameter int IMAGE_WIDTH  = 208,
  parameter int IMAGE_HEIGHT = 160
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ccrs_pkg::cfg_t        cfg,
  input  logic                  q_valid,
  input  ccrs_pkg::class_word_t q_word,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ccrs_pkg::result_t     out_res
);

  localparam int CW = ccrs_pkg::COL_W;
  localparam logic [CW-1:0] WLAST = CW'(IMAGE_WIDTH - 1);
  localparam logic [CW:0]   HEIGHT = (CW + 1)'(IMAGE_HEIGHT);

  logic [7:0]    prev_class;
  logic [CW-1:0] run_begin, column, row;
  logic          pend_valid;
  ccrs_pkg::result_t pend_res;

  logic          load;
  logic [CW-1:0] col_eff, row_eff;
  logic [CW:0]   row_inc;
  logic          row_end, changed, has_a, has_b, keep_a, keep_b, two;
  logic [7:0]    cls;
  ccrs_pkg::result_t res_a, res_b, res_none, first_res;

  assign load = !out_valid || out_ready;
  assign pop  = load && !pend_valid && q_valid;

  assign cls     = q_word.cls;
  assign col_eff = q_word.frame_start ? '0 : column;
  assign row_eff = q_word.frame_start ? '0 : row;
  assign row_inc = {1'b0, row_eff} + 1'b1;
  assign row_end = col_eff >= WLAST;
  assign changed = cls != prev_class;
  assign has_a   = (col_eff != '0) && (row_end || changed);
  assign has_b   = (col_eff != '0) && row_end && changed;
  assign keep_a  = has_a && ((prev_class & cfg.class_mask) < cfg.usable_class_limit);
  assign keep_b  = has_b && ((cls & cfg.class_mask) < cfg.usable_class_limit);
  assign two     = keep_a && keep_b;

  always_comb begin
    res_a.pixel_class  = cls;
    res_a.seg_valid    = 1'b1;
    res_a.seg_row      = row_eff;
    res_a.seg_first    = run_begin;
    res_a.seg_last_col = row_end ? (changed ? WLAST - 1'b1 : WLAST) : col_eff - 1'b1;
    res_a.seg_class    = prev_class;
    res_a.last         = !two;

    res_b.pixel_class  = cls;
    res_b.seg_valid    = 1'b1;
    res_b.seg_row      = row_eff;
    res_b.seg_first    = WLAST;
    res_b.seg_last_col = WLAST;
    res_b.seg_class    = cls;
    res_b.last         = 1'b1;

    res_none              = '0;
    res_none.pixel_class  = cls;
    res_none.last         = 1'b1;

    if (keep_a) begin
      first_res = res_a;
    end else if (keep_b) begin
      first_res = res_b;
    end else begin
      first_res = res_none;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
      prev_class <= '0;
      run_begin  <= '0;
      column     <= '0;
      row        <= '0;
    end else if (load) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (q_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= two;
        prev_class <= cls;
        if (row_end) begin
          column    <= '0;
          run_begin <= '0;
          row       <= (row_inc >= HEIGHT) ? '0 : row_inc[CW-1:0];
        end else begin
          column <= col_eff + 1'b1;
          row    <= row_eff;
          if (col_eff == '0) begin
            run_begin <= '0;
          end else if (changed) begin
            run_begin <= col_eff;
          end
        end
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_valid) begin
        out_res <= pend_res;
      end else if (q_valid) begin
        out_res  <= first_res;
        pend_res <= res_b;
      end
    end
  end

endmodule

>>> hw/rtl/color_class_run_segmenter_unit.sv
// color class run segmenter: table lookup classification and row run segments
// depends on ccrs_pkg, ccrs_front, ccrs_queue, ccrs_back
// a pixel word passes quantize, index and table read registers and the queue before its first result is registered
// throughput: one word per cycle while in_ready is high; a pixel closing two segments
//   gives two result words from the output register, the 8-entry queue absorbs the difference
// reset clears counters and run state and loads the config defaults; the color table is not cleared
`timescale 1ns / 1ps

module color_class_run_segmenter_unit #(
  parameter int IMAGE_WIDTH   = 208,
  parameter int IMAGE_HEIGHT  = 160,
  parameter int QUANT_DIVISOR = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [7:0]                    luma,
  input  logic [7:0]                    chroma_u,
  input  logic [7:0]                    chroma_v,
  input  logic                          frame_start,
  input  logic [ccrs_pkg::TABLE_AW-1:0] table_addr,
  input  logic [7:0]                    table_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    pixel_class,
  output logic                          seg_valid,
  output logic [ccrs_pkg::COL_W-1:0]    seg_row,
  output logic [ccrs_pkg::COL_W-1:0]    seg_first,
  output logic [ccrs_pkg::COL_W-1:0]    seg_last_col,
  output logic [7:0]                    seg_class,
  output logic                          last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [7:0]                    cfg_data
);

  ccrs_pkg::cfg_t        cfg;
  ccrs_pkg::class_word_t push_word, q_word;
  ccrs_pkg::result_t     out_res;
  logic                  push, pop, q_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.usable_class_limit <= 8'd10;
      cfg.class_mask         <= 8'd255;
    end else if (cfg_valid) begin
      case (cfg_index)
        ccrs_pkg::CFG_LIMIT: cfg.usable_class_limit <= cfg_data;
        ccrs_pkg::CFG_MASK:  cfg.class_mask         <= cfg_data;
        default: ;
      endcase
    end
  end

  ccrs_front #(
    .QUANT_DIVISOR(QUANT_DIVISOR)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .luma        (luma),
    .chroma_u    (chroma_u),
    .chroma_v    (chroma_v),
    .frame_start (frame_start),
    .table_addr  (table_addr),
    .table_data  (table_data),
    .pop         (pop),
    .push        (push),
    .push_word   (push_word)
  );

  ccrs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_word    (q_word)
  );

  ccrs_back #(
    .IMAGE_WIDTH (IMAGE_WIDTH),
    .IMAGE_HEIGHT(IMAGE_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign pixel_class  = out_res.pixel_class;
  assign seg_valid    = out_res.seg_valid;
  assign seg_row      = out_res.seg_row;
  assign seg_first    = out_res.seg_first;
  assign seg_last_col = out_res.seg_last_col;
  assign seg_class    = out_res.seg_class;
  assign last         = out_res.last;

endmodule

>>> sim/tb.sv
// testbench for color_class_run_segmenter_unit: random and directed pixel and
// table words, class prediction and row run segments checked word by word
// depends on ccrs_pkg and the color_class_run_segmenter_unit rtl
`timescale 1ns / 1ps

module tb;

  localparam int IMG_W        = 208;
  localparam int IMG_H        = 160;
  localparam int QD           = 4;
  localparam int LEVELS       = 255 / QD + 1;
  localparam int TBL_DEPTH    = 1 << ccrs_pkg::TABLE_AW;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 12;

  class seg_scoreboard;
    logic [7:0]  entry_cls [int unsigned];
    logic [7:0]  prev_cls;
    logic [7:0]  limit;
    logic [7:0]  mask;
    int unsigned col;
    int unsigned row;
    int unsigned run_start;
    ccrs_pkg::result_t expected_q[$];
    ccrs_pkg::result_t batch[$];
    int          mismatches;

    function new();
      prev_cls   = 8'h00;
      col        = 0;
      row        = 0;
      run_start  = 0;
      limit      = 8'd10;
      mask       = 8'hFF;
      mismatches = 0;
    endfunction

    function void set_reg(logic idx, logic [7:0] val);
      if (idx == ccrs_pkg::CFG_LIMIT) begin
        limit = val;
      end else begin
        mask = val;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // closes a run; dropped when the masked class is not usable
    function void close_run(logic [7:0] pc, int unsigned first, int unsigned lastc,
                            logic [7:0] c);
      ccrs_pkg::result_t r;
      if ((c & mask) >= limit) return;
      r              = '0;
      r.pixel_class  = pc;
      r.seg_valid    = 1'b1;
      r.seg_row      = ccrs_pkg::COL_W'(row);
      r.seg_first    = ccrs_pkg::COL_W'(first);
      r.seg_last_col = ccrs_pkg::COL_W'(lastc);
      r.seg_class    = c;
      batch.push_back(r);
    endfunction

    function void note_word(logic k, logic [7:0] y, logic [7:0] u, logic [7:0] v,
                            logic fs, logic [ccrs_pkg::TABLE_AW-1:0] addr,
                            logic [7:0] data);
      int unsigned idx;
      int unsigned wlast;
      logic [7:0]  cls;
      ccrs_pkg::result_t r;
      if (k == ccrs_pkg::KIND_TABLE) begin
        entry_cls[addr] = data;
        return;
      end
      if (fs) begin
        row = 0;
        col = 0;
      end
      idx = (((int'(y) / QD) * LEVELS + int'(u) / QD) * LEVELS + int'(v) / QD) % TBL_DEPTH;
      cls = entry_cls.exists(idx) ? entry_cls[idx] : 8'h00;
      wlast = IMG_W - 1;
      batch.delete();
      if (col == 0) begin
        run_start = 0;
      end else if (col >= wlast) begin
        if (cls != prev_cls) begin
          close_run(cls, run_start, wlast - 1, prev_cls);
          close_run(cls, wlast, wlast, cls);
        end else begin
          close_run(cls, run_start, wlast, prev_cls);
        end
      end else if (cls != prev_cls) begin
        close_run(cls, run_start, col - 1, prev_cls);
        run_start = col;
      end
      prev_cls = cls;
      if (batch.size() == 0) begin
        r             = '0;
        r.pixel_class = cls;
        batch.push_back(r);
      end
      foreach (batch[i]) begin
        r      = batch[i];
        r.last = (i == batch.size() - 1);
        expected_q.push_back(r);
      end
      if (col >= wlast) begin
        col       = 0;
        run_start = 0;
        row       = (row + 1 >= IMG_H) ? 0 : row + 1;
      end else begin
        col = col + 1;
      end
    endfunction

    function void cmp(string fld, logic [15:0] want_v, logic [15:0] got_v);
      if (want_v !== got_v) begin
        $error("%s: expected %0d, got %0d", fld, want_v, got_v);
        mismatches++;
      end
    endfunction

    function void check_word(ccrs_pkg::result_t got);
      ccrs_pkg::result_t want;
      if (expected_q.size() == 0) begin
        $error("result word with nothing pending: pixel_class %0d", got.pixel_class);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      cmp("pixel_class", want.pixel_class, got.pixel_class);
      cmp("seg_valid", want.seg_valid, got.seg_valid);
      cmp("seg_row", want.seg_row, got.seg_row);
      cmp("seg_first", want.seg_first, got.seg_first);
      cmp("seg_last_col", want.seg_last_col, got.seg_last_col);
      cmp("seg_class", want.seg_class, got.seg_class);
      cmp("last", want.last, got.last);
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic                          kind;
  logic [7:0]                    luma;
  logic [7:0]                    chroma_u;
  logic [7:0]                    chroma_v;
  logic                          frame_start;
  logic [ccrs_pkg::TABLE_AW-1:0] table_addr;
  logic [7:0]                    table_data;
  logic                          out_valid;
  logic                          out_ready;
  logic [7:0]                    pixel_class;
  logic                          seg_valid;
  logic [ccrs_pkg::COL_W-1:0]    seg_row;
  logic [ccrs_pkg::COL_W-1:0]    seg_first;
  logic [ccrs_pkg::COL_W-1:0]    seg_last_col;
  logic [7:0]                    seg_class;
  logic                          last;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic                          cfg_index;
  logic [7:0]                    cfg_data;

  seg_scoreboard sb = new();
  bit            calm = 1'b0;
  bit            hold_out = 1'b0;
  int unsigned   filled_q[$];
  bit            is_filled [int unsigned];

  color_class_run_segmenter_unit #(
    .IMAGE_WIDTH  (IMG_W),
    .IMAGE_HEIGHT (IMG_H),
    .QUANT_DIVISOR(QD)
  ) u_top (.*);

  always #2 clk = ~clk;

  // receiver side
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_out) begin
        repeat (HOLD_CYCLES) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
        hold_out = 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 37);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_word({pixel_class, seg_valid, seg_row, seg_first, seg_last_col, seg_class,
                     last});
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_word(input logic k, input logic [7:0] y, input logic [7:0] u,
                           input logic [7:0] v, input logic fs,
                           input logic [ccrs_pkg::TABLE_AW-1:0] addr,
                           input logic [7:0] data);
    while (!calm && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    luma        <= y;
    chroma_u    <= u;
    chroma_v    <= v;
    frame_start <= fs;
    table_addr  <= addr;
    table_data  <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(k, y, u, v, fs, addr, data);
  endtask

  function automatic logic [7:0] quant_sample(int unsigned q);
    int unsigned s;
    s = q * QD + $urandom_range(0, QD - 1);
    return (s > 255) ? 8'hFF : s[7:0];
  endfunction

  task automatic send_pixel(input int unsigned idx, input logic fs);
    send_word(ccrs_pkg::KIND_PIXEL, quant_sample(idx / (LEVELS * LEVELS)),
              quant_sample((idx / LEVELS) % LEVELS), quant_sample(idx % LEVELS), fs,
              ccrs_pkg::TABLE_AW'($urandom), 8'($urandom));
  endtask

  task automatic write_entry(input int unsigned addr, input logic [7:0] data);
    if (!is_filled.exists(addr)) begin
      is_filled[addr] = 1'b1;
      filled_q.push_back(addr);
    end
    send_word(ccrs_pkg::KIND_TABLE, 8'($urandom), 8'($urandom), 8'($urandom),
              1'($urandom), addr[ccrs_pkg::TABLE_AW-1:0], data);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] lim, input logic [7:0] msk);
    settle();
    write_reg(ccrs_pkg::CFG_LIMIT, lim);
    write_reg(ccrs_pkg::CFG_MASK, msk);
  endtask

  // runs of one table entry with random lengths, mixed with table updates
  task automatic run_phase(input int n_items, input bit allow_fs);
    int unsigned run_idx;
    int unsigned run_left;
    int unsigned roll;
    int unsigned addr;
    run_idx  = filled_q[0];
    run_left = 0;
    for (int i = 0; i < n_items; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        if ($urandom_range(0, 99) < 40) begin
          addr = filled_q[$urandom_range(0, filled_q.size() - 1)];
        end else begin
          addr = $urandom_range(0, TBL_DEPTH - 1);
        end
        write_entry(addr, ($urandom_range(0, 99) < 65) ? 8'($urandom_range(0, 15))
                                                        : 8'($urandom));
      end else begin
        if (run_left == 0) begin
          run_idx  = filled_q[$urandom_range(0, filled_q.size() - 1)];
          run_left = $urandom_range(1, 24);
        end
        run_left--;
        send_pixel(run_idx, allow_fs && roll >= 98);
      end
    end
  endtask

  initial begin
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    kind        <= ccrs_pkg::KIND_TABLE;
    luma        <= 8'h00;
    chroma_u    <= 8'h00;
    chroma_v    <= 8'h00;
    frame_start <= 1'b0;
    table_addr  <= '0;
    table_data  <= 8'h00;
    cfg_valid   <= 1'b0;
    cfg_index   <= ccrs_pkg::CFG_LIMIT;
    cfg_data    <= 8'h00;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: table extremes, limit boundary, write then read, mid-row frame start
    write_entry(0, 8'd3);
    write_entry(TBL_DEPTH - 1, 8'hFF);
    write_entry(18'h15555, 8'h00);
    write_entry(18'h2AAAA, 8'hAA);
    write_entry(18'h00041, 8'd9);
    write_entry(18'h01000, 8'd10);
    send_word(ccrs_pkg::KIND_PIXEL, 8'h00, 8'h00, 8'h00, 1'b1, '0, 8'h00);
    send_pixel(0, 1'b0);
    send_word(ccrs_pkg::KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b0, '1, 8'hFF);
    send_pixel(18'h00041, 1'b0);
    send_pixel(18'h01000, 1'b0);
    send_pixel(0, 1'b0);
    write_entry(0, 8'd4);
    send_pixel(0, 1'b0);
    send_pixel(18'h15555, 1'b0);
    send_pixel(0, 1'b1);
    send_pixel(18'h2AAAA, 1'b0);
    for (int i = 0; i < 8; i++) begin
      write_entry($urandom_range(0, TBL_DEPTH - 1), 8'($urandom_range(0, 15)));
    end

    run_phase(60, 1'b1);
    set_config(8'd0, 8'hFF);
    run_phase(50, 1'b1);
    set_config(8'd255, 8'h00);
    hold_out = 1'b1;
    run_phase(90, 1'b0);
    set_config(8'd255, 8'hFF);
    calm = 1'b1;
    run_phase(90, 1'b0);
    settle();
    calm = 1'b0;
    set_config(8'd12, 8'h0F);
    run_phase(60, 1'b0);
    set_config(8'd200, 8'hF0);
    run_phase(60, 1'b0);

    // frame start, then a stretch without one so the row runs to its end
    set_config(8'd5, 8'h07);
    send_pixel(filled_q[0], 1'b1);
    run_phase(230, 1'b0);
    settle();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/ccrs_pkg.sv
hw/rtl/ccrs_front.sv
hw/rtl/ccrs_queue.sv
hw/rtl/ccrs_back.sv
hw/rtl/color_class_run_segmenter_unit.sv
sim/tb.sv
